// ----- rtl/bbc_pkg.sv -----
// ----------------------------------------------------------------------------
// Buffer cache package
// Shared types and constants of the block buffer cache tag engine.
// ----------------------------------------------------------------------------
package bbc_pkg;

   localparam int DefNumBuffers = 32;
   localparam int DefNumBuckets = 13;

   localparam int DevW  = 8;
   localparam int BlkW  = 24;
   localparam int RefW  = 8;
   localparam int TimeW = 32;
   localparam int IdxW  = 5;

   localparam logic [RefW-1:0] RefMax = 8'hFF;

   typedef enum logic [1:0] {
      REQ_GET     = 2'd0,
      REQ_RELEASE = 2'd1,
      REQ_PIN     = 2'd2,
      REQ_UNPIN   = 2'd3
   } req_type_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NO_FREE = 2'd1,
      ST_COUNT   = 2'd2,
      ST_UNUSED  = 2'd3
   } status_type;

   // One stored entry, kept as a single memory word.
   typedef struct packed {
      logic [DevW-1:0]  device;
      logic [BlkW-1:0]  block;
      logic [RefW-1:0]  refs;
      logic [TimeW-1:0] rtime;
      logic             valid;
   } entry_type;

   localparam int EntryW = $bits(entry_type);

endpackage

// ----- rtl/bbc_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module bbc_ram #(
   parameter int Width = 8,
   parameter int Depth = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- rtl/bbc_mod.sv -----
// ----------------------------------------------------------------------------
// Bucket modulo
// Home bucket of a block number by reciprocal multiplication, ready in the cycle
// after start.
// ----------------------------------------------------------------------------
module bbc_mod #(
   parameter int NumBuckets = 13,
   parameter int BktW = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [bbc_pkg::BlkW-1:0]  value,
   output logic                      done,
   output logic [BktW-1:0]           remainder
);
   import bbc_pkg::*;

   // The quotient is (value * Recip) >> Sh. With Sh = BlkW + ceil(log2(NumBuckets)) and
   // Recip = floor(2^Sh / NumBuckets) + 1 the quotient is exact for every BlkW-bit value.
   localparam int LogB  = (NumBuckets > 1) ? $clog2(NumBuckets) : 0;
   localparam int Sh    = BlkW + LogB;
   localparam int MW    = BlkW + 2;
   localparam int PW    = BlkW + MW;
   localparam logic [MW-1:0] Recip = MW'(((64'd1 << Sh) / 64'(NumBuckets)) + 64'd1);

   logic [PW-1:0]   prod;
   logic [BlkW-1:0] quot_ff, quot_in;
   logic [BlkW-1:0] val_ff, val_in;
   logic [BlkW-1:0] rem_full;
   logic            busy_ff, busy_in;

   always_comb begin
      prod    = PW'(value) * PW'(Recip);
      quot_in = quot_ff;
      val_in  = val_ff;
      busy_in = start;
      if (start) begin
         quot_in = BlkW'(prod >> Sh);
         val_in  = value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      quot_ff <= quot_in;
      val_ff  <= val_in;
   end

   // The quotient times the bucket count never exceeds the value, so BlkW bits hold it.
   assign rem_full  = val_ff - BlkW'(quot_ff * BlkW'(NumBuckets));
   assign done      = busy_ff;
   assign remainder = rem_full[BktW-1:0];

endmodule

// ----- rtl/block_buffer_cache_lru_top.sv -----
// Steps: a get finds the home bucket, then scans the entries in order, reading each one and
// finding the bucket of each free entry, stops early on a hit, and writes the chosen entry
// back. Release, pin and unpin read and write the one named entry; an out-of-range index is
// answered without a memory access. One request at a time: a new request is taken only after
// the response to the last one has been transferred.
// Reset: a clearing pass writes zero to every entry, with req_ready low.
// ----------------------------------------------------------------------------
// Block buffer cache top
// Tag lookup and LRU victim selection over an entry memory.
// ----------------------------------------------------------------------------
module block_buffer_cache_lru_top #(
   parameter int NUM_BUFFERS = bbc_pkg::DefNumBuffers,
   parameter int NUM_BUCKETS = bbc_pkg::DefNumBuckets
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [1:0]                 req_req_type,
   input  logic [bbc_pkg::DevW-1:0]   req_device_id,
   input  logic [bbc_pkg::BlkW-1:0]   req_block_number,
   input  logic [bbc_pkg::IdxW-1:0]   req_buffer_index,
   input  logic [bbc_pkg::TimeW-1:0]  req_now_tick,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [bbc_pkg::IdxW-1:0]   rsp_result_index,
   output logic                       rsp_was_hit,
   output logic                       rsp_needs_read,
   output logic [1:0]                 rsp_status
);
   import bbc_pkg::*;

   localparam int AW   = $clog2(NUM_BUFFERS);
   localparam int CW   = AW + 1;
   localparam int BktW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;

   // State machine: clear pass, idle, home bucket, scan, candidate bucket, single-entry read and write, respond.
   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_HOME  = 7'b0000100,
      S_SCAN  = 7'b0001000,
      S_EMOD  = 7'b0010000,
      S_ONE   = 7'b0100000,
      S_RESP  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   // Captured request.
   logic [1:0]       rtype_ff;
   logic [DevW-1:0]  dev_ff;
   logic [BlkW-1:0]  blk_ff;
   logic [IdxW-1:0]  idx_ff;
   logic [TimeW-1:0] now_ff;
   logic [BktW-1:0]  home_ff, home_in;

   // Scan bookkeeping.
   logic [CW-1:0]    addr_ff, addr_in;
   logic [AW-1:0]    cur_ff, cur_in;
   entry_type        cur_ent_ff, cur_ent_in;
   logic             found_ff, found_in, have_ff, have_in;
   logic [AW-1:0]    best_ff, best_in;
   logic [BktW-1:0]  best_d_ff, best_d_in;
   logic [TimeW-1:0] best_t_ff, best_t_in;
   entry_type        best_ent_ff, best_ent_in;

   // Response register.
   logic             rv_ff, rv_in;
   logic [IdxW-1:0]  ridx_ff, ridx_in;
   logic             rhit_ff, rhit_in, rrd_ff, rrd_in;
   logic [1:0]       rst_ff, rst_in;

   // Memory ports.
   logic             wr_en;
   logic [AW-1:0]    wr_addr, rd_addr;
   entry_type        wr_data, rd_data;

   bbc_ram #(.Width(EntryW), .Depth(NUM_BUFFERS)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // Modulo unit, shared between the home bucket and each candidate's bucket.
   logic             mod_start, mod_done;
   logic [BlkW-1:0]  mod_val;
   logic [BktW-1:0]  mod_rem;

   bbc_mod #(.NumBuckets(NUM_BUCKETS), .BktW(BktW)) u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .value    (mod_val),
      .done     (mod_done),
      .remainder(mod_rem)
   );

   logic             req_fire, rsp_fire, idx_ok, rd_pending_ff;
   logic [BktW:0]    dist_w;
   logic [BktW-1:0]  bkt_dist;
   logic [AW-1:0]    tgt;

   assign req_ready = (state_ff == S_IDLE) && !rv_ff;
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rv_ff && rsp_ready;
   assign idx_ok    = {{(CW > IdxW ? CW-IdxW : 0){1'b0}}, req_buffer_index} < (CW > IdxW ? CW : IdxW)'(NUM_BUFFERS);
   assign tgt       = AW'(idx_ff);

   // Distance from home bucket, with wrap.
   assign dist_w   = (mod_rem >= home_ff) ? {1'b0, mod_rem - home_ff}
                   : {1'b0, mod_rem} + (BktW+1)'(NUM_BUCKETS) - {1'b0, home_ff};
   assign bkt_dist = dist_w[BktW-1:0];

   always_comb begin
      state_in    = state_ff;
      addr_in     = addr_ff;
      cur_in      = cur_ff;
      cur_ent_in  = cur_ent_ff;
      found_in    = found_ff;
      have_in     = have_ff;
      best_in     = best_ff;
      best_d_in   = best_d_ff;
      best_t_in   = best_t_ff;
      best_ent_in = best_ent_ff;
      home_in     = home_ff;
      rv_in       = rv_ff && !rsp_fire;
      ridx_in     = ridx_ff;
      rhit_in     = rhit_ff;
      rrd_in      = rrd_ff;
      rst_in      = rst_ff;
      wr_en       = 1'b0;
      wr_addr     = addr_ff[AW-1:0];
      wr_data     = '0;
      rd_addr     = addr_ff[AW-1:0];
      mod_start   = 1'b0;
      mod_val     = rd_data.block;

      unique case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1;
            addr_in = addr_ff + 1'b1;
            if (addr_ff == CW'(NUM_BUFFERS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               addr_in = '0;
               found_in = 1'b0;
               have_in = 1'b0;
               if (req_req_type == REQ_GET) begin
                  mod_start = 1'b1;
                  mod_val   = req_block_number;
                  state_in  = S_HOME;
               end else if (idx_ok) begin
                  state_in = S_ONE;
               end else begin
                  rv_in = 1'b1; ridx_in = req_buffer_index;
                  rhit_in = 1'b0; rrd_in = 1'b0; rst_in = ST_OK;
               end
            end
            rd_addr = AW'(req_buffer_index);
         end
         S_HOME: begin
            rd_addr = '0;
            if (mod_done) begin
               home_in  = mod_rem;
               addr_in  = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // rd_data holds entry addr_ff when rd_pending_ff is set.
            rd_addr = addr_ff[AW-1:0];
            if (rd_pending_ff) begin
               cur_in = addr_ff[AW-1:0];
               cur_ent_in = rd_data;
               if (rd_data.device == dev_ff && rd_data.block == blk_ff) begin
                  found_in = 1'b1;
                  best_in = addr_ff[AW-1:0];
                  best_ent_in = rd_data;
                  state_in = S_RESP;
               end else if (rd_data.refs == '0 && !found_ff) begin
                  mod_start = 1'b1;
                  state_in = S_EMOD;
               end else begin
                  addr_in = addr_ff + 1'b1;
                  if (addr_ff == CW'(NUM_BUFFERS - 1)) begin
                     state_in = S_RESP;
                  end
               end
            end
         end
         S_EMOD: begin
            rd_addr = cur_ff;
            if (mod_done) begin
               if (!have_ff || bkt_dist < best_d_ff ||
                   (bkt_dist == best_d_ff && cur_ent_ff.rtime < best_t_ff)) begin
                  have_in = 1'b1;
                  best_in = cur_ff;
                  best_d_in = bkt_dist;
                  best_t_in = cur_ent_ff.rtime;
                  best_ent_in = cur_ent_ff;
               end
               addr_in = addr_ff + 1'b1;
               state_in = (addr_ff == CW'(NUM_BUFFERS - 1)) ? S_RESP : S_SCAN;
               rd_addr = addr_in[AW-1:0];
            end
         end
         S_ONE: begin
            rd_addr = tgt;
            wr_addr = tgt;
            if (rd_pending_ff) begin
               wr_data = rd_data;
               rv_in = 1'b1; ridx_in = idx_ff; rhit_in = 1'b0; rrd_in = 1'b0;
               rst_in = ST_OK;
               state_in = S_IDLE;
               if (rtype_ff == REQ_PIN) begin
                  if (rd_data.refs == RefMax) rst_in = ST_COUNT;
                  else begin wr_en = 1'b1; wr_data.refs = rd_data.refs + 1'b1; end
               end else begin
                  if (rd_data.refs == '0) rst_in = ST_COUNT;
                  else begin
                     wr_en = 1'b1;
                     wr_data.refs = rd_data.refs - 1'b1;
                     if (rtype_ff == REQ_RELEASE && rd_data.refs == RefW'(1))
                        wr_data.rtime = now_ff;
                  end
               end
            end
         end
         S_RESP: begin
            wr_addr = best_ff;
            wr_data = best_ent_ff;
            rv_in = 1'b1;
            rrd_in = 1'b0;
            rst_in = ST_OK;
            ridx_in = IdxW'(best_ff);
            state_in = S_IDLE;
            if (found_ff) begin
               rhit_in = 1'b1;
               if (best_ent_ff.refs == RefMax) rst_in = ST_COUNT;
               else begin
                  wr_en = 1'b1;
                  wr_data.refs = best_ent_ff.refs + 1'b1;
                  wr_data.valid = 1'b1;
                  rrd_in = !best_ent_ff.valid;
               end
            end else if (have_ff) begin
               rhit_in = 1'b0;
               wr_en = 1'b1;
               wr_data.device = dev_ff;
               wr_data.block = blk_ff;
               wr_data.refs = RefW'(1);
               wr_data.valid = 1'b1;
               rrd_in = 1'b1;
            end else begin
               rhit_in = 1'b0;
               ridx_in = '0;
               rst_in = ST_NO_FREE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         addr_ff  <= '0;
         rv_ff    <= 1'b0;
         rd_pending_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
         rv_ff    <= rv_in;
         // Read data is good in the cycle after its address was held, in scan, home, candidate bucket or idle.
         rd_pending_ff <= ((state_ff == S_SCAN) && !rd_pending_ff) ||
                          ((state_ff == S_HOME) && mod_done) ||
                          ((state_ff == S_EMOD) && mod_done) ||
                          (state_ff == S_IDLE && req_fire);
      end
      cur_ff      <= cur_in;
      cur_ent_ff  <= cur_ent_in;
      found_ff    <= found_in;
      have_ff     <= have_in;
      best_ff     <= best_in;
      best_d_ff   <= best_d_in;
      best_t_ff   <= best_t_in;
      best_ent_ff <= best_ent_in;
      home_ff     <= home_in;
      ridx_ff     <= ridx_in;
      rhit_ff     <= rhit_in;
      rrd_ff      <= rrd_in;
      rst_ff      <= rst_in;
      if (req_fire) begin
         rtype_ff <= req_req_type;
         dev_ff   <= req_device_id;
         blk_ff   <= req_block_number;
         idx_ff   <= req_buffer_index;
         now_ff   <= req_now_tick;
      end
   end

   assign rsp_valid        = rv_ff;
   assign rsp_result_index = ridx_ff;
   assign rsp_was_hit      = rhit_ff;
   assign rsp_needs_read   = rrd_ff;
   assign rsp_status       = rst_ff;

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> !rv_ff) else $error("request taken while response pending");
   a_no_free_idx: assert property (@(posedge clock) disable iff (reset)
      rv_ff && rst_ff == ST_NO_FREE |-> ridx_ff == '0 && !rhit_ff)
      else $error("no-free response malformed");
   a_hit_no_status1: assert property (@(posedge clock) disable iff (reset)
      rv_ff && rhit_ff |-> rst_ff != ST_NO_FREE) else $error("hit with no-free");
`endif

endmodule

// ----- test/bbc_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Buffer cache checker
// Watches the request and response channels, predicts each response from its
// own copy of the entry store and compares field by field.
// ----------------------------------------------------------------------------
module bbc_checker
   import bbc_pkg::*;
#(
   parameter int NUM_BUFFERS = DefNumBuffers,
   parameter int NUM_BUCKETS = DefNumBuckets
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  logic [1:0]       req_req_type,
   input  logic [DevW-1:0]  req_device_id,
   input  logic [BlkW-1:0]  req_block_number,
   input  logic [IdxW-1:0]  req_buffer_index,
   input  logic [TimeW-1:0] req_now_tick,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  logic [IdxW-1:0]  rsp_result_index,
   input  logic             rsp_was_hit,
   input  logic             rsp_needs_read,
   input  logic [1:0]       rsp_status,
   output int               fail_count,
   output int               pending_count
);

   typedef struct packed {
      logic [IdxW-1:0] index;
      logic            hit;
      logic            read;
      status_type      status;
   } answer_type;

   logic [DevW-1:0]  model_dev   [NUM_BUFFERS];
   logic [BlkW-1:0]  model_blk   [NUM_BUFFERS];
   logic [RefW-1:0]  model_refs  [NUM_BUFFERS];
   logic [TimeW-1:0] model_time  [NUM_BUFFERS];
   logic             model_valid [NUM_BUFFERS];
   answer_type       answers_due [$];

   task automatic report(input string what);
      $display("mismatch at %0t: %s", $time, what);
      fail_count++;
   endtask

   function automatic answer_type serve_request(input req_type_type kind,
         input logic [DevW-1:0] dev, input logic [BlkW-1:0] blk,
         input logic [IdxW-1:0] idx, input logic [TimeW-1:0] now);
      answer_type a;
      int found, best, best_d, d, home;
      logic [TimeW-1:0] best_t;
      a = '{index: idx, hit: 1'b0, read: 1'b0, status: ST_OK};
      if (kind == REQ_GET) begin
         home = blk % NUM_BUCKETS;
         found = -1;
         for (int i = NUM_BUFFERS - 1; i >= 0; i--)
            if (model_dev[i] == dev && model_blk[i] == blk) found = i;
         if (found >= 0) begin
            a.index = IdxW'(found);
            a.hit = 1'b1;
            if (model_refs[found] == RefMax) begin
               a.status = ST_COUNT;
            end else begin
               model_refs[found]++;
               a.read = !model_valid[found];
               model_valid[found] = 1'b1;
            end
         end else begin
            best = -1; best_d = 0; best_t = '0;
            for (int i = 0; i < NUM_BUFFERS; i++) begin
               if (model_refs[i] != 0) continue;
               d = (model_blk[i] % NUM_BUCKETS + NUM_BUCKETS - home) % NUM_BUCKETS;
               if (best < 0 || d < best_d || (d == best_d && model_time[i] < best_t)) begin
                  best = i; best_d = d; best_t = model_time[i];
               end
            end
            if (best >= 0) begin
               model_dev[best] = dev;
               model_blk[best] = blk;
               model_refs[best] = RefW'(1);
               model_valid[best] = 1'b1;
               a.index = IdxW'(best);
               a.read = 1'b1;
            end else begin
               a.index = '0;
               a.status = ST_NO_FREE;
            end
         end
      end else if (idx < NUM_BUFFERS) begin
         if (kind == REQ_PIN) begin
            if (model_refs[idx] == RefMax) a.status = ST_COUNT;
            else model_refs[idx]++;
         end else if (model_refs[idx] == 0) begin
            a.status = ST_COUNT;
         end else begin
            model_refs[idx]--;
            if (kind == REQ_RELEASE && model_refs[idx] == 0) model_time[idx] = now;
         end
      end
      return a;
   endfunction

   always @(posedge clock) begin
      answer_type got, want;
      if (reset) begin
         fail_count <= 0;
         pending_count <= 0;
         answers_due.delete();
         for (int i = 0; i < NUM_BUFFERS; i++) begin
            model_dev[i] = '0; model_blk[i] = '0; model_refs[i] = '0;
            model_time[i] = '0; model_valid[i] = 1'b0;
         end
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = '{index: rsp_result_index, hit: rsp_was_hit, read: rsp_needs_read,
                    status: status_type'(rsp_status)};
            if (answers_due.size() == 0) begin
               report("response with nothing outstanding");
            end else begin
               want = answers_due.pop_front();
               if (got.index !== want.index)
                  report($sformatf("result_index %0d, want %0d", got.index, want.index));
               if (got.hit !== want.hit)
                  report($sformatf("was_hit %0b, want %0b", got.hit, want.hit));
               if (got.read !== want.read)
                  report($sformatf("needs_read %0b, want %0b", got.read, want.read));
               if (got.status !== want.status)
                  report($sformatf("status %0d, want %0d", got.status, want.status));
            end
         end
         if (req_valid && req_ready)
            answers_due.push_back(serve_request(req_type_type'(req_req_type),
               req_device_id, req_block_number, req_buffer_index, req_now_tick));
         pending_count <= answers_due.size();
      end
   end

endmodule

// ----- test/tb_block_buffer_cache_lru_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Buffer cache testbench
// Drives get, release, pin and unpin requests against the buffer cache with
// random idling on both sides; a checker module predicts and compares.
// ----------------------------------------------------------------------------
module tb_block_buffer_cache_lru_top;
   import bbc_pkg::*;

   localparam int NBuf = DefNumBuffers;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic [1:0]       req_req_type = '0;
   logic [DevW-1:0]  req_device_id = '0;
   logic [BlkW-1:0]  req_block_number = '0;
   logic [IdxW-1:0]  req_buffer_index = '0;
   logic [TimeW-1:0] req_now_tick = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [IdxW-1:0]  rsp_result_index;
   logic             rsp_was_hit;
   logic             rsp_needs_read;
   logic [1:0]       rsp_status;
   int               fail_count;
   int               pending_count;

   // Sender and receiver behavior is steered by these flags from the stimulus process.
   bit               calm_phase = 1'b0;
   bit               hold_request = 1'b0;
   logic [TimeW-1:0] tick = 32'd1000;

   always #10 clock = ~clock;

   block_buffer_cache_lru_top dut (.*);

   bbc_checker checker_i (.*);

   // Blocks are drawn from a small pool so that hits, bucket sharing and
   // reuse of released entries happen often; a few draws are fully random.
   function automatic logic [BlkW-1:0] pick_block();
      case ($urandom_range(0, 9))
         0:       return BlkW'($urandom());
         1:       return BlkW'(24'hFFFFFF - $urandom_range(0, 3));
         default: return BlkW'($urandom_range(0, 40));
      endcase
   endfunction

   // Offers one request and holds it until the transfer happens. Sender idle
   // bursts come before the offer, outside the calm final stretch; valid stays
   // high between back-to-back offers.
   task automatic send(input req_type_type kind, input logic [DevW-1:0] dev,
         input logic [BlkW-1:0] blk, input logic [IdxW-1:0] idx,
         input logic [TimeW-1:0] now);
      if (!calm_phase && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_req_type     <= kind;
      req_device_id    <= dev;
      req_block_number <= blk;
      req_buffer_index <= idx;
      req_now_tick     <= now;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_random();
      int r;
      logic [IdxW-1:0] idx;
      r = $urandom_range(0, 99);
      idx = IdxW'($urandom());
      tick = tick + $urandom_range(0, 3);
      if ($urandom_range(0, 19) == 0) tick = $urandom();
      if (r < 45)
         send(REQ_GET, DevW'($urandom_range(0, 3)), pick_block(), idx, tick);
      else if (r < 75)
         send(REQ_RELEASE, DevW'($urandom()), BlkW'($urandom()), idx, tick);
      else if (r < 88)
         send(REQ_PIN, DevW'($urandom()), BlkW'($urandom()), idx, tick);
      else
         send(REQ_UNPIN, DevW'($urandom()), BlkW'($urandom()), idx, tick);
   endtask

   // The sender stops offering and waits until every response has come.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // Receiver: random stall bursts, none in the calm phase, and a long
   // hold-off on request of the stimulus process.
   initial begin
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_request = 1'b0;
         end else if (!calm_phase && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part. A fresh store hits at entry zero for device 0 block 0
      // with a read due, then misses take free entries by bucket order.
      send(REQ_GET, 8'd0, 24'd0, 5'd0, tick);
      send(REQ_GET, 8'd255, 24'hFFFFFF, 5'd31, tick);
      send(REQ_GET, 8'd0, 24'd0, 5'd0, tick);
      send(REQ_RELEASE, 8'hFF, 24'hFFFFFF, 5'd0, 32'hFFFFFFFF);
      send(REQ_RELEASE, 8'h00, 24'h000000, 5'd0, 32'h00000000);
      // Release and unpin with nothing held are count errors.
      send(REQ_RELEASE, 8'd0, 24'd0, 5'd0, tick);
      send(REQ_UNPIN, 8'd0, 24'd0, 5'd5, tick);
      send(REQ_PIN, 8'd0, 24'd0, 5'd5, tick);
      // Unpin to zero leaves the release time alone.
      send(REQ_UNPIN, 8'd0, 24'd0, 5'd5, tick);
      send(REQ_GET, 8'd7, 24'd13, 5'd0, tick);
      send(REQ_GET, 8'd7, 24'd26, 5'd0, tick);
      send(REQ_GET, 8'd7, 24'd12, 5'd0, tick);
      // Pin one entry up to its ceiling, then one more pin overflows, and a get of a block not yet held follows.
      for (int i = 0; i < 256; i++) send(REQ_PIN, 8'd0, 24'd0, 5'd9, tick);
      send(REQ_GET, 8'd3, 24'd99, 5'd0, tick);
      drain();

      // Take every free entry with distinct blocks so that the later misses find none free.
      for (int i = 0; i < NBuf + 1; i++)
         send(REQ_GET, 8'd200, BlkW'(1000 + i), 5'd0, tick);
      // Release every entry once with varied stamps to set up the replacement order.
      for (int i = 0; i < NBuf; i++) begin
         send(REQ_RELEASE, 8'd0, 24'd0, 5'(i), $urandom());
      end
      drain();

      // Long receiver hold-off while the sender keeps offering requests.
      hold_request = 1'b1;
      for (int i = 0; i < 40; i++) send_random();
      drain();

      for (int i = 0; i < 980; i++) begin
         if (i == 830) calm_phase = 1'b1;
         send_random();
      end
      drain();
      repeat (200) @(posedge clock);
      if (fail_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

   initial begin
      #(80_000_000);
      $display("TB_ERROR");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/bbc_pkg.sv
rtl/bbc_ram.sv
rtl/bbc_mod.sv
rtl/block_buffer_cache_lru_top.sv
test/bbc_checker.sv
test/tb_block_buffer_cache_lru_top.sv
